/* rtl/volume_fade_envelope_unit_assert.svh */
// Assertion macros for the volume fade envelope unit.
// Needs no other file; included by the top level only.
`ifndef VOLUME_FADE_ENVELOPE_UNIT_ASSERT_SVH
`define VOLUME_FADE_ENVELOPE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define VFE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vfe assertion failed");
`define VFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vfe assertion failed");
`else
`define VFE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VFE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/vfe_pkg.sv */
// Shared types and constants of the volume fade envelope unit.
// No dependencies; used by every other file of the block but the assert header.
package vfe_pkg;

  localparam int unsigned LevelW     = 16;
  localparam int unsigned StepW      = 16;
  localparam int unsigned CfgW       = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned LevelShift = 15;
  localparam int unsigned FracShift  = 8;
  localparam int unsigned QueueDepth = 2;

  localparam logic [LevelW-1:0] UnityLevel = 16'h8000;
  localparam logic [ByteW-1:0]  ByteMax    = 8'hff;
  localparam logic [CfgW-1:0]   CfgGainReset = 16'd256;
  localparam logic [CfgW-1:0]   CfgMaskReset = 16'd0;

  typedef enum logic [1:0] {
    FadeNone     = 2'd0,
    FadeIn       = 2'd1,
    FadeOutStop  = 2'd2,
    FadeOutPause = 2'd3
  } fade_mode_e;

  typedef enum logic {
    KindTick  = 1'b0,
    KindStart = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgChanVol   = 2'd0,
    CfgChanGain  = 2'd1,
    CfgTrackGain = 2'd2,
    CfgTrackSel  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BackIdle,
    BackMulA,
    BackMulP,
    BackMulT,
    BackDone
  } back_state_e;

  typedef struct packed {
    logic [CfgW-1:0] chan_vol;
    logic [CfgW-1:0] chan_gain;
    logic [CfgW-1:0] track_gain;
    logic [CfgW-1:0] track_sel;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              stop;
    logic              pause;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* rtl/vfe_ifs.sv */
// Valid/ready channel interfaces for the input items and the results.
// Depends on vfe_pkg for the field widths.
interface vfe_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [1:0]                  fade_mode;
  logic [vfe_pkg::StepW-1:0]   fade_step;
  logic [vfe_pkg::LevelW-1:0]  start_level;

  modport source (output valid, kind, fade_mode, fade_step, start_level, input ready);
  modport sink   (input valid, kind, fade_mode, fade_step, start_level, output ready);
endinterface

interface vfe_out_if;
  logic                        valid;
  logic                        ready;
  logic [vfe_pkg::ByteW-1:0]   bus_volume;
  logic [vfe_pkg::ByteW-1:0]   track_volume;
  logic [vfe_pkg::CfgW-1:0]    track_mask;
  logic                        stop_request;
  logic                        pause_request;

  modport source (output valid, bus_volume, track_volume, track_mask, stop_request,
                  pause_request, input ready);
  modport sink   (input valid, bus_volume, track_volume, track_mask, stop_request,
                  pause_request, output ready);
endinterface

/* rtl/vfe_front.sv */
// Front end: accepts input beats, holds the envelope state and advances it.
// Depends on vfe_pkg and vfe_in_if; pushes one job per beat into the queue.
module vfe_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  vfe_in_if.sink                   in_i,
  input  vfe_pkg::q_status_t       q_status_i,
  output logic                     push_o,
  output vfe_pkg::job_t            job_o
);

  vfe_pkg::fade_mode_e              mode_q, mode_d;
  logic [vfe_pkg::LevelW-1:0]       level_q, level_d;
  logic [vfe_pkg::StepW-1:0]        step_q, step_d;
  logic [vfe_pkg::LevelW-1:0]       sum;
  logic                             stop, pause;

  assign in_i.ready = !q_status_i.full;
  assign push_o     = in_i.valid && in_i.ready;
  assign sum        = level_q + step_q;

  always_comb begin
    mode_d  = mode_q;
    level_d = level_q;
    step_d  = step_q;
    stop    = 1'b0;
    pause   = 1'b0;
    if (push_o) begin
      if (vfe_pkg::kind_e'(in_i.kind) == vfe_pkg::KindStart) begin
        mode_d  = vfe_pkg::fade_mode_e'(in_i.fade_mode);
        step_d  = in_i.fade_step;
        level_d = in_i.start_level;
      end else begin
        unique case (mode_q)
          vfe_pkg::FadeIn: begin
            // The wrapped sum reaching bit 15 ends the fade at unity.
            if (sum[vfe_pkg::LevelW-1]) begin
              mode_d  = vfe_pkg::FadeNone;
              level_d = vfe_pkg::UnityLevel;
              step_d  = '0;
            end else begin
              level_d = sum;
            end
          end
          vfe_pkg::FadeOutStop: begin
            if (level_q < step_q) begin
              mode_d  = vfe_pkg::FadeNone;
              level_d = '0;
              stop    = 1'b1;
            end else begin
              level_d = level_q - step_q;
            end
          end
          vfe_pkg::FadeOutPause: begin
            if (level_q < step_q) begin
              level_d = '0;
              pause   = 1'b1;
            end else begin
              level_d = level_q - step_q;
            end
          end
          vfe_pkg::FadeNone: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign job_o.level = level_d;
  assign job_o.stop  = stop;
  assign job_o.pause = pause;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= vfe_pkg::FadeNone;
      level_q <= vfe_pkg::UnityLevel;
      step_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      level_q <= level_d;
      step_q  <= step_d;
    end
  end

endmodule

/* rtl/vfe_queue.sv */
// Short job queue between the front end and the multiplier back end.
// Depends on vfe_pkg for the job and status types.
module vfe_queue #(
  parameter int unsigned DEPTH = vfe_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  vfe_pkg::job_t        job_i,
  input  logic                 pop_i,
  output vfe_pkg::job_t        job_o,
  output vfe_pkg::q_status_t   status_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  vfe_pkg::job_t   mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == CntW'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign job_o          = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

/* rtl/vfe_back.sv */
// Back end: scales each queued level by the gains over three multiply steps.
// Depends on vfe_pkg and vfe_out_if; holds the result until the sink takes it.
module vfe_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vfe_pkg::cfg_t        cfg_i,
  input  vfe_pkg::job_t        job_i,
  input  vfe_pkg::q_status_t   q_status_i,
  output logic                 pop_o,
  vfe_out_if.source            out_o
);

  localparam int unsigned ProdAW = 2 * vfe_pkg::CfgW;
  localparam int unsigned ProdPW = ProdAW + vfe_pkg::LevelW;
  localparam int unsigned BusLsb = vfe_pkg::LevelShift + vfe_pkg::FracShift;
  localparam int unsigned VolLsb = 2 * vfe_pkg::FracShift;
  localparam int unsigned ProdTW = ProdPW - VolLsb + vfe_pkg::CfgW;
  localparam int unsigned TrkLsb = vfe_pkg::LevelShift;

  vfe_pkg::back_state_e   state_q, state_d;
  vfe_pkg::job_t          job_q;
  logic [ProdAW-1:0]      a_q;
  logic [ProdPW-1:0]      p_q;
  logic [ProdTW-1:0]      t_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vfe_pkg::BackIdle: if (!q_status_i.empty) state_d = vfe_pkg::BackMulA;
      vfe_pkg::BackMulA: state_d = vfe_pkg::BackMulP;
      vfe_pkg::BackMulP: state_d = vfe_pkg::BackMulT;
      vfe_pkg::BackMulT: state_d = vfe_pkg::BackDone;
      vfe_pkg::BackDone: if (out_o.ready) state_d = vfe_pkg::BackIdle;
      default:           state_d = vfe_pkg::BackIdle;
    endcase
  end

  always_comb begin
    pop_o       = (state_q == vfe_pkg::BackIdle) && !q_status_i.empty;
    out_o.valid = (state_q == vfe_pkg::BackDone);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vfe_pkg::BackIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Volume times gain first, then the level, then the track gain on the 17.15 value.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (state_q == vfe_pkg::BackMulA) begin
      a_q <= ProdAW'(cfg_i.chan_vol) * ProdAW'(cfg_i.chan_gain);
    end
    if (state_q == vfe_pkg::BackMulP) begin
      p_q <= ProdPW'(a_q) * ProdPW'(job_q.level);
    end
    if (state_q == vfe_pkg::BackMulT) begin
      t_q <= ProdTW'(p_q[ProdPW-1:VolLsb]) * ProdTW'(cfg_i.track_gain);
    end
  end

  assign out_o.bus_volume   = (|p_q[ProdPW-1:BusLsb+vfe_pkg::ByteW]) ? vfe_pkg::ByteMax
                                                                     : p_q[BusLsb +: vfe_pkg::ByteW];
  assign out_o.track_volume = (|t_q[ProdTW-1:TrkLsb+vfe_pkg::ByteW]) ? vfe_pkg::ByteMax
                                                                     : t_q[TrkLsb +: vfe_pkg::ByteW];
  assign out_o.track_mask    = cfg_i.track_sel;
  assign out_o.stop_request  = job_q.stop;
  assign out_o.pause_request = job_q.pause;

endmodule

/* rtl/volume_fade_envelope_unit.sv */
// Top level of the volume fade envelope unit: configuration registers and wiring.
// Depends on vfe_pkg, vfe_ifs, vfe_front, vfe_queue, vfe_back and the assert header.
//
//   channel  direction  beat contents
//   in_i     sink       kind, fade_mode, fade_step, start_level
//   out_o    source     bus_volume, track_volume, track_mask, stop/pause request
//   cfg      write      cfg_we_i, cfg_idx_i, cfg_data_i
//
// A result is presented once its input beat has been pushed into the queue, popped by
// the back end and taken through three multiply steps, each on its own multiplier;
// then the result holds. The back end works on one item at a time. The front end keeps
// taking beats until the queue is full, so a stalled output does not block input at
// once. Reset clears the envelope, the queue and the back end and sets the
// configuration registers to their reset values.
`include "volume_fade_envelope_unit_assert.svh"

module volume_fade_envelope_unit #(
  parameter int unsigned QUEUE_DEPTH = vfe_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  vfe_in_if.sink                       in_i,
  vfe_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [vfe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vfe_pkg::CfgW-1:0]     cfg_data_i
);

  vfe_pkg::cfg_t       cfg_q;
  vfe_pkg::job_t       push_job, pop_job;
  vfe_pkg::q_status_t  q_status;
  logic                q_push, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chan_vol   <= vfe_pkg::CfgGainReset;
      cfg_q.chan_gain  <= vfe_pkg::CfgGainReset;
      cfg_q.track_gain <= vfe_pkg::CfgGainReset;
      cfg_q.track_sel  <= vfe_pkg::CfgMaskReset;
    end else if (cfg_we_i) begin
      unique case (vfe_pkg::cfg_idx_e'(cfg_idx_i))
        vfe_pkg::CfgChanVol:   cfg_q.chan_vol   <= cfg_data_i;
        vfe_pkg::CfgChanGain:  cfg_q.chan_gain  <= cfg_data_i;
        vfe_pkg::CfgTrackGain: cfg_q.track_gain <= cfg_data_i;
        vfe_pkg::CfgTrackSel:  cfg_q.track_sel  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  vfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (q_push),
    .job_o      (push_job)
  );

  vfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .job_i    (push_job),
    .pop_i    (q_pop),
    .job_o    (pop_job),
    .status_o (q_status)
  );

  vfe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_i      (pop_job),
    .q_status_i (q_status),
    .pop_o      (q_pop),
    .out_o      (out_o)
  );

  // A tick cannot end in both a stop and a pause.
  `VFE_ASSERT_IMP(a_single_request, clk_i, rst_ni, q_push, !(push_job.stop && push_job.pause))
  // Any request is raised only with the level at zero.
  `VFE_ASSERT_IMP(a_request_at_zero, clk_i, rst_ni, q_push && (push_job.stop || push_job.pause),
                  push_job.level == '0)
  // The back end never takes a new job while a result is waiting.
  `VFE_ASSERT_IMP(a_no_pop_while_valid, clk_i, rst_ni, out_o.valid, !q_pop)
  // After a pop the queue cannot have been full unless a push came with it.
  `VFE_ASSERT_NEXT(a_pop_frees_slot, clk_i, rst_ni, q_pop && !q_push, !q_status.full)

endmodule

/* tb/vfe_envelope_checker.sv */
// Checker for the volume fade envelope unit: watches both channels and the
// configuration port, predicts every result beat and compares it.
// Depends on vfe_pkg and the channel interfaces in vfe_ifs.
module vfe_envelope_checker import vfe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  vfe_in_if                   in_mon,
  vfe_out_if                  out_mon,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    logic [ByteW-1:0] bus_volume;
    logic [ByteW-1:0] track_volume;
    logic [CfgW-1:0]  track_mask;
    logic             stop_request;
    logic             pause_request;
  } mix_beat_t;

  // Shadow copy of the envelope and of the configuration registers.
  fade_mode_e        env_mode;
  logic [LevelW-1:0] env_level;
  logic [StepW-1:0]  env_step;
  logic [CfgW-1:0]   chan_vol;
  logic [CfgW-1:0]   chan_gain;
  logic [CfgW-1:0]   trk_gain;
  logic [CfgW-1:0]   trk_sel;

  mix_beat_t   expected_mix[$];
  int unsigned fails;
  int unsigned mismatches;

  function automatic logic [ByteW-1:0] clip_byte(input logic [63:0] v);
    return (v > 64'(ByteMax)) ? ByteMax : v[ByteW-1:0];
  endfunction

  // Applies one input beat to the shadow envelope and returns the mix it yields.
  function automatic mix_beat_t next_mix(input kind_e k, input fade_mode_e m,
                                         input logic [StepW-1:0] s,
                                         input logic [LevelW-1:0] l);
    mix_beat_t   r;
    logic [63:0] scaled;
    r = '0;
    if (k == KindStart) begin
      env_mode  = m;
      env_step  = s;
      env_level = l;
    end else begin
      case (env_mode)
        FadeIn: begin
          env_level = env_level + env_step;
          if (env_level[LevelW-1]) begin
            env_mode  = FadeNone;
            env_level = UnityLevel;
            env_step  = '0;
          end
        end
        FadeOutStop: begin
          if (env_level < env_step) begin
            env_mode       = FadeNone;
            env_level      = '0;
            r.stop_request = 1'b1;
          end else begin
            env_level = env_level - env_step;
          end
        end
        FadeOutPause: begin
          // The mode is kept, so with a non-zero step a pause is requested again on every later tick.
          if (env_level < env_step) begin
            env_level       = '0;
            r.pause_request = 1'b1;
          end else begin
            env_level = env_level - env_step;
          end
        end
        default: ;
      endcase
    end
    scaled = (64'(chan_vol) * 64'(chan_gain) * 64'(env_level)) >> FracShift;
    r.bus_volume   = clip_byte(scaled >> LevelShift);
    r.track_volume = clip_byte(((scaled >> FracShift) * 64'(trk_gain)) >> LevelShift);
    r.track_mask   = trk_sel;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    mix_beat_t got;
    mix_beat_t want;
    if (!rst_ni) begin
      env_mode   = FadeNone;
      env_level  = UnityLevel;
      env_step   = '0;
      chan_vol   = CfgGainReset;
      chan_gain  = CfgGainReset;
      trk_gain   = CfgGainReset;
      trk_sel    = CfgMaskReset;
      expected_mix.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgChanVol:   chan_vol  = cfg_data_i;
          CfgChanGain:  chan_gain = cfg_data_i;
          CfgTrackGain: trk_gain  = cfg_data_i;
          CfgTrackSel:  trk_sel   = cfg_data_i;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.bus_volume, out_mon.track_volume, out_mon.track_mask,
                out_mon.stop_request, out_mon.pause_request};
        if (expected_mix.size() == 0) begin
          fails++;
          if (mismatches < 10) begin
            $display("%0t: result beat with nothing expected: bus %0d track %0d mask %h",
                     $time, got.bus_volume, got.track_volume, got.track_mask);
          end
          mismatches++;
        end else begin
          want = expected_mix.pop_front();
          if (got.bus_volume !== want.bus_volume || got.track_volume !== want.track_volume ||
              got.track_mask !== want.track_mask || got.stop_request !== want.stop_request ||
              got.pause_request !== want.pause_request) begin
            fails++;
            if (mismatches < 10) begin
              $display("%0t: mismatch: expected bus %0d track %0d mask %h stop %0b pause %0b",
                       $time, want.bus_volume, want.track_volume, want.track_mask,
                       want.stop_request, want.pause_request);
              $display("%0t:           got      bus %0d track %0d mask %h stop %0b pause %0b",
                       $time, got.bus_volume, got.track_volume, got.track_mask,
                       got.stop_request, got.pause_request);
            end
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_mix.push_back(next_mix(kind_e'(in_mon.kind), fade_mode_e'(in_mon.fade_mode),
                                        in_mon.fade_step, in_mon.start_level));
      end
      pending_o <= expected_mix.size();
    end
    fail_count_o <= fails;
  end

endmodule

/* tb/tb.sv */
// Top of the volume fade envelope testbench: clock, reset, stimulus and verdict.
// Depends on vfe_pkg, vfe_ifs, the unit itself and vfe_envelope_checker.
module tb;
  import vfe_pkg::*;

  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned SegmentBeats = 244;
  localparam int unsigned Segments     = 8;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgW-1:0]     cfg_data;
  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         idle_pct;
  int unsigned         stall_pct;
  int unsigned         cycles;

  vfe_in_if  in_ch ();
  vfe_out_if out_ch ();

  volume_fade_envelope_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  vfe_envelope_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Presents one beat after a random gap and returns at the edge that takes it.
  task automatic send_item(input kind_e k, input fade_mode_e m,
                           input logic [StepW-1:0] s, input logic [LevelW-1:0] l);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= k;
    in_ch.fade_mode   <= m;
    in_ch.fade_step   <= s;
    in_ch.start_level <= l;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Tick beats carry random fields which the block must ignore.
  task automatic tick_beats(input int unsigned n);
    repeat (n) begin
      send_item(KindTick, fade_mode_e'($urandom_range(3)), 16'($urandom),
                16'($urandom_range(0, 32768)));
    end
  endtask

  // Registers may only change once the unit has gone quiet.
  task automatic load_settings(input logic [CfgW-1:0] vol, input logic [CfgW-1:0] gain,
                               input logic [CfgW-1:0] tgain, input logic [CfgW-1:0] tsel);
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgChanVol;
    cfg_data <= vol;
    @(posedge clk_i);
    cfg_idx  <= CfgChanGain;
    cfg_data <= gain;
    @(posedge clk_i);
    cfg_idx  <= CfgTrackGain;
    cfg_data <= tgain;
    @(posedge clk_i);
    cfg_idx  <= CfgTrackSel;
    cfg_data <= tsel;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    int unsigned       seg;
    int unsigned       sent;
    int unsigned       ticks;
    int unsigned       pick;
    logic [StepW-1:0]  step;
    logic [LevelW-1:0] level;
    rst_ni            = 1'b0;
    cycles            = 0;
    idle_pct          = 0;
    stall_pct         = 0;
    cfg_we            = 1'b0;
    cfg_idx           = CfgChanVol;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KindTick;
    in_ch.fade_mode   = FadeNone;
    in_ch.fade_step   = '0;
    in_ch.start_level = '0;
    out_ch.ready      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A tick straight after reset must report the unity level.
    tick_beats(1);
    load_settings(16'd128, 16'd256, 16'd256, 16'ha5c3);
    send_item(KindStart, FadeNone, 16'hffff, UnityLevel);
    tick_beats(1);
    // Fade in from silence until the level settles at unity.
    send_item(KindStart, FadeIn, 16'h2000, 16'h0000);
    tick_beats(4);
    // The sum wraps past 16 bits and first lands at zero.
    send_item(KindStart, FadeIn, 16'h8000, UnityLevel);
    tick_beats(2);
    send_item(KindStart, FadeIn, 16'hffff, 16'h7fff);
    tick_beats(1);
    send_item(KindStart, FadeOutStop, 16'h3000, UnityLevel);
    tick_beats(4);
    // A pausing fade keeps asking for a pause once it has reached zero.
    send_item(KindStart, FadeOutPause, 16'hffff, 16'h0100);
    tick_beats(2);
    send_item(KindStart, FadeOutStop, 16'h0000, 16'h1234);
    tick_beats(1);
    // Landing exactly on zero does not stop; the following tick does.
    send_item(KindStart, FadeOutStop, 16'h0005, 16'h0005);
    tick_beats(2);

    for (seg = 0; seg < Segments; seg++) begin
      case (seg)
        0: load_settings(16'd256, 16'd256, 16'd256, 16'h0000);
        1: load_settings(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        2: load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        4, 6: load_settings(16'($urandom_range(0, 512)), 16'($urandom_range(0, 512)),
                            16'($urandom_range(0, 512)), 16'($urandom));
        5: load_settings(16'd128, 16'd512, 16'd1024, 16'($urandom));
        default: load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      sent = 0;
      while (sent < SegmentBeats) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          // A fade start followed by a run of ticks; small steps give long fades.
          case ($urandom_range(9))
            0: step = 16'h0000;
            1: step = 16'hffff;
            2: step = 16'h8000;
            3: step = 16'($urandom);
            default: step = 16'($urandom_range(1, 4096));
          endcase
          case ($urandom_range(4))
            0: level = 16'h0000;
            1: level = UnityLevel;
            default: level = 16'($urandom_range(0, 32768));
          endcase
          ticks = $urandom_range(1, 20);
          send_item(KindStart, fade_mode_e'($urandom_range(3)), step, level);
          tick_beats(ticks);
          sent += ticks + 1;
        end else if (pick < 90) begin
          ticks = $urandom_range(1, 3);
          tick_beats(ticks);
          sent += ticks;
        end else begin
          send_item(KindStart, fade_mode_e'($urandom_range(3)), 16'($urandom),
                    16'($urandom_range(0, 32768)));
          sent++;
        end
      end
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
